// ----- hw/rtl/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared constants, types and the start byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned MaxUnits      = 3;
  localparam int unsigned UnitIdxWidth  = $clog2(MaxUnits + 1);
  localparam int unsigned PointWidth    = 21;

  localparam logic [15:0] SurrHighBase  = 16'hD800;
  localparam logic [15:0] SurrLowBase   = 16'hDC00;
  localparam logic [15:0] SurrLowLast   = 16'hDFFF;
  localparam logic [15:0] TermUnit      = 16'h0000;
  localparam logic [PointWidth-1:0] SuppBase = 21'h010000;

  localparam logic        AppendTermReset = 1'b1;

  // Result of looking at a byte as the first byte of a sequence.
  typedef struct packed {
    logic       valid;   // a legal start byte
    logic [6:0] bits;    // payload bits carried by the start byte
    logic [1:0] extra;   // continuation bytes it needs
  } lead_t;

  function automatic lead_t decode_lead(input logic [7:0] b);
    lead_t r;
    r = '{valid: 1'b0, bits: 7'd0, extra: 2'd0};
    if (b[7] == 1'b0) begin
      r = '{valid: 1'b1, bits: b[6:0], extra: 2'd0};
    end else if (b[7:5] == 3'b110) begin
      r = '{valid: 1'b1, bits: {2'b00, b[4:0]}, extra: 2'd1};
    end else if (b[7:4] == 4'b1110) begin
      r = '{valid: 1'b1, bits: {3'b000, b[3:0]}, extra: 2'd2};
    end else if (b[7:3] == 5'b11110) begin
      r = '{valid: 1'b1, bits: {4'b0000, b[2:0]}, extra: 2'd3};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_to_utf16_transcoder_top.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream into UTF-16 code units, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one UTF-8 byte per item together with the
//   number of string bytes that follow it, saturated at three; zero marks the
//   last byte of a string. The output channel gives UTF-16 code units, with
//   run_last_o set on the last unit caused by an input byte. After the last
//   byte of a string an optional zero terminator follows, selected by the
//   one-bit configuration register (set after reset).
//   An accepted byte is held in the input register and, once the result
//   buffer is free, is decoded into that buffer of up to three units, from
//   which its first unit is offered. The result buffer drains one unit per
//   cycle while out_ready_i is high, and a byte causing no units only passes
//   through the input register; with a unit or less per byte and no receiver
//   stall the block takes one byte every cycle.
//   Reset clears the decoder state, empties both registers and sets the
//   terminator option. When the receiver stalls, the buffer holds its unit,
//   the input register fills, and then in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_top
  import u8u16_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_write_en_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [1:0]  bytes_following_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      code_unit_o,
  output logic             run_last_o
);

  // Configuration.
  logic append_q;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic [1:0] s1_bf_q;

  // Decoder state.
  logic [PointWidth-1:0] partial_q, partial_d;
  logic [1:0]            expect_q, expect_d;
  logic                  discard_q, discard_d;

  // Result buffer.
  logic                    buf_valid_q;
  logic [15:0]             units_q [MaxUnits];
  logic [15:0]             units_d [MaxUnits];
  logic [UnitIdxWidth-1:0] cnt_q, cnt_d;
  logic [UnitIdxWidth-1:0] idx_q;
  logic                    buf_last;

  logic in_fire, out_fire, s1_adv, buf_free;

  assign buf_last    = (idx_q == cnt_q - UnitIdxWidth'(1));
  assign out_valid_o = buf_valid_q;
  assign code_unit_o = units_q[idx_q[1:0]];
  assign run_last_o  = buf_last;
  assign out_fire    = out_valid_o && out_ready_i;
  assign buf_free    = !buf_valid_q || (out_fire && buf_last);
  assign s1_adv      = s1_valid_q && buf_free;
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_fire     = in_valid_i && in_ready_o;

  // ------------------------------------------------------------------
  // Decode of the byte in the input register.
  // ------------------------------------------------------------------
  lead_t                 lead;
  logic                  is_cont;
  logic [PointWidth-1:0] shifted;
  logic                  pt_emit;
  logic [PointWidth-1:0] pt_cp;
  logic                  term;
  logic                  pt_big;
  logic [PointWidth-1:0] cp_off;
  logic [15:0]           unit_hi, unit_lo, unit_bmp;

  assign lead    = decode_lead(s1_byte_q);
  assign is_cont = (s1_byte_q[7:6] == 2'b10);
  assign shifted = {partial_q[PointWidth-7:0], s1_byte_q[5:0]};

  always_comb begin
    partial_d = partial_q;
    expect_d  = expect_q;
    discard_d = discard_q;
    pt_emit   = 1'b0;
    pt_cp     = '0;
    term      = 1'b0;
    if (!discard_q) begin
      if (expect_q != 2'd0 && is_cont) begin
        partial_d = shifted;
        expect_d  = expect_q - 2'd1;
        if (expect_q == 2'd1) begin
          pt_emit   = 1'b1;
          pt_cp     = shifted;
          partial_d = '0;
        end
      end else begin
        // A non-continuation byte drops any open sequence and starts anew.
        if (expect_q != 2'd0) begin
          partial_d = '0;
          expect_d  = 2'd0;
        end
        if (lead.valid) begin
          if (lead.extra == 2'd0) begin
            pt_emit = 1'b1;
            pt_cp   = {{(PointWidth-7){1'b0}}, lead.bits};
          end else if (s1_bf_q < lead.extra) begin
            discard_d = 1'b1;
          end else begin
            partial_d = {{(PointWidth-7){1'b0}}, lead.bits};
            expect_d  = lead.extra;
          end
        end
      end
    end
    if (s1_bf_q == 2'd0) begin
      term      = append_q;
      partial_d = '0;
      expect_d  = 2'd0;
      discard_d = 1'b0;
    end
  end

  // Code point to UTF-16; the high half is truncated to 16 bits.
  assign pt_big   = |pt_cp[PointWidth-1:16];
  assign cp_off   = pt_cp - SuppBase;
  assign unit_bmp = pt_cp[15:0];
  assign unit_hi  = SurrHighBase + {5'b00000, cp_off[20:10]};
  assign unit_lo  = SurrLowBase | {6'b000000, cp_off[9:0]};

  always_comb begin
    units_d[0] = TermUnit;
    units_d[1] = TermUnit;
    units_d[2] = TermUnit;
    cnt_d      = UnitIdxWidth'(term);
    if (pt_emit) begin
      if (pt_big) begin
        units_d[0] = unit_hi;
        units_d[1] = unit_lo;
        cnt_d      = UnitIdxWidth'(2) + UnitIdxWidth'(term);
      end else begin
        units_d[0] = unit_bmp;
        cnt_d      = UnitIdxWidth'(1) + UnitIdxWidth'(term);
      end
    end
  end

  // ------------------------------------------------------------------
  // Registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_q    <= AppendTermReset;
      s1_valid_q  <= 1'b0;
      partial_q   <= '0;
      expect_q    <= 2'd0;
      discard_q   <= 1'b0;
      buf_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
    end else begin
      if (cfg_write_en_i) begin
        append_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        partial_q <= partial_d;
        expect_q  <= expect_d;
        discard_q <= discard_d;
      end
      if (s1_adv && cnt_d != '0) begin
        buf_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
        idx_q       <= '0;
      end else if (out_fire) begin
        if (buf_last) begin
          buf_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + UnitIdxWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= byte_value_i;
      s1_bf_q   <= bytes_following_i;
    end
    if (s1_adv && cnt_d != '0) begin
      units_q <= units_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder checker
// Port-level properties of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_checker
  import u8u16_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] code_unit_o,
  input wire logic        run_last_o
);

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  // Nothing is offered while reset is applied.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // A stalled unit holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_unit_o)
      && $stable(run_last_o))
    else $error("stalled unit changed");

  // The rest of an item's units follow without a gap.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !run_last_o |=> out_valid_o)
    else $error("item's units interrupted");

  // A high surrogate that is not last is followed by a low half or the terminator.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !run_last_o && code_unit_o >= SurrHighBase && code_unit_o < SurrLowBase
      |=> (code_unit_o >= SurrLowBase && code_unit_o <= SurrLowLast)
          || code_unit_o == TermUnit)
    else $error("surrogate pair out of order");

  // A zero unit that is not last can only be followed by the terminator.
  a_zero_then_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !run_last_o && code_unit_o == TermUnit
      |=> code_unit_o == TermUnit && run_last_o)
    else $error("zero unit not followed by terminator");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_u8u16_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .code_unit_o (code_unit_o),
  .run_last_o  (run_last_o)
);

`default_nettype wire

// ----- sim/utf8_to_utf16_transcoder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// A short table of hand-picked bytes comes first, then random strings: mostly
// well-formed UTF-8 with random content, the rest truncated, corrupted, noisy
// or with odd byte counts. Every accepted byte runs through a local decoder
// model, and each code unit that leaves the block is checked in order against
// it or a directed byte's listed units. Both handshakes idle at random, and
// the terminator option is toggled between phases while the block is idle.
// ----------------------------------------------------------------------------

module utf8_to_utf16_transcoder_top_tb;
  import u8u16_pkg::*;

  localparam int DirCount   = 27;
  localparam int PhaseBytes = 50;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } utf16_unit_t;

  typedef struct packed {
    logic [7:0] b;
    logic [1:0] bf;
  } utf8_byte_t;

  // A directed byte; when known is set, the n listed units are what it must give.
  typedef struct packed {
    logic [7:0]  b;
    logic [1:0]  bf;
    logic        known;
    logic [1:0]  n;
    logic [15:0] u0;
    logic [15:0] u1;
    logic [15:0] u2;
  } byte_case_t;

  typedef enum int {
    FlawNone,
    FlawSwap,
    FlawCut,
    FlawNoise,
    FlawLooseCount,
    FlawEarlyEnd
  } string_flaw_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_write_en_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_value_i;
  logic [1:0]  bytes_following_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] code_unit_o;
  logic        run_last_o;

  // Decoder model state.
  logic [20:0] cp_acc;
  logic [1:0]  cont_left;
  logic        drop_rest;
  logic        term_on;

  utf16_unit_t pending_units[$];
  utf8_byte_t  text_bytes[$];
  byte_case_t  dir_rows[DirCount];

  int  mismatch_count;
  int  units_checked;
  int  bytes_sent;
  int  bytes_used;
  int  strings_sent;
  bit  sender_quiet;
  bit  hold_out;
  int  hold_left;
  int  stall_left;
  int  calm_left;

  utf8_to_utf16_transcoder_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_write_en_i    (cfg_write_en_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .byte_value_i      (byte_value_i),
    .bytes_following_i (bytes_following_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .code_unit_o       (code_unit_o),
    .run_last_o        (run_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Advances the model by one byte and returns the code units it gives.
  function automatic void decode_utf8_byte(input logic [7:0] b, input logic [1:0] bf,
                                           output int n, output logic [2:0][15:0] u,
                                           output logic used);
    logic [20:0] ofs;
    logic [20:0] lead_bits;
    int          need;
    n = 0;
    u = '0;
    used = !drop_rest;
    need = 0;
    lead_bits = '0;
    ofs = '0;
    if (!drop_rest) begin
      if (cont_left != 2'd0 && b[7:6] == 2'b10) begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          if (cp_acc < SuppBase) begin
            u[n] = cp_acc[15:0];
            n++;
          end else begin
            ofs = cp_acc - SuppBase;
            u[n] = SurrHighBase + {5'b00000, ofs[20:10]};
            u[n+1] = SurrLowBase + {6'b000000, ofs[9:0]};
            n += 2;
          end
          cp_acc = '0;
        end
      end else begin
        // Anything but a continuation byte restarts decoding at this byte.
        cont_left = 2'd0;
        cp_acc = '0;
        if (!b[7]) begin
          u[n] = {8'h00, b};
          n++;
        end else begin
          if (b[7:5] == 3'b110) begin
            lead_bits = {16'd0, b[4:0]};
            need = 1;
          end else if (b[7:4] == 4'b1110) begin
            lead_bits = {17'd0, b[3:0]};
            need = 2;
          end else if (b[7:3] == 5'b11110) begin
            lead_bits = {18'd0, b[2:0]};
            need = 3;
          end
          if (need != 0) begin
            if (int'(bf) < need) begin
              drop_rest = 1'b1;
            end else begin
              cp_acc = lead_bits;
              cont_left = need[1:0];
            end
          end
        end
      end
    end
    if (bf == 2'd0) begin
      if (term_on) begin
        u[n] = TermUnit;
        n++;
      end
      cp_acc = '0;
      cont_left = 2'd0;
      drop_rest = 1'b0;
    end
  endfunction

  // Fills text_bytes with one string, mostly well-formed, sometimes damaged.
  function automatic void build_string();
    logic [7:0]   raw[$];
    logic [31:0]  r;
    int           pick;
    int           pos;
    int           len;
    string_flaw_e flaw;
    utf8_byte_t   item;
    raw = {};
    text_bytes = {};
    pick = $urandom_range(0, 99);
    if (pick < 65) flaw = FlawNone;
    else if (pick < 72) flaw = FlawSwap;
    else if (pick < 79) flaw = FlawCut;
    else if (pick < 85) flaw = FlawNoise;
    else if (pick < 92) flaw = FlawLooseCount;
    else flaw = FlawEarlyEnd;
    if (flaw == FlawNoise) begin
      repeat ($urandom_range(1, 8)) raw.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        r = $urandom;
        case ($urandom_range(0, 3))
          0: raw.push_back({1'b0, r[6:0]});
          1: begin
            raw.push_back({3'b110, r[4:0]});
            raw.push_back({2'b10, r[10:5]});
          end
          2: begin
            raw.push_back({4'b1110, r[3:0]});
            raw.push_back({2'b10, r[9:4]});
            raw.push_back({2'b10, r[15:10]});
          end
          default: begin
            raw.push_back({5'b11110, r[2:0]});
            raw.push_back({2'b10, r[8:3]});
            raw.push_back({2'b10, r[14:9]});
            raw.push_back({2'b10, r[20:15]});
          end
        endcase
      end
    end
    if (flaw == FlawSwap) raw[$urandom_range(0, raw.size() - 1)] = 8'($urandom_range(0, 255));
    if (flaw == FlawCut && raw.size() > 1) begin
      repeat ($urandom_range(1, raw.size() - 1)) void'(raw.pop_back());
    end
    len = raw.size();
    for (int i = 0; i < len; i++) begin
      item.b = raw[i];
      item.bf = (len - 1 - i > 3) ? 2'd3 : 2'(len - 1 - i);
      if (flaw == FlawLooseCount && item.bf != 2'd0 && $urandom_range(0, 1) == 1) begin
        item.bf = 2'($urandom_range(1, 3));
      end
      text_bytes.push_back(item);
    end
    // A zero count in the middle closes the string early.
    if (flaw == FlawEarlyEnd && len > 1) begin
      pos = $urandom_range(0, len - 2);
      text_bytes[pos].bf = 2'd0;
    end
    strings_sent++;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [1:0] bf, input logic known,
                           input logic [1:0] kn, input logic [2:0][15:0] ku);
    int               gap;
    int               n;
    logic [2:0][15:0] u;
    logic             used;
    utf16_unit_t      want;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= b;
    bytes_following_i <= bf;
    do @(posedge clk_i); while (!in_ready_o);
    decode_utf8_byte(b, bf, n, u, used);
    if (known) begin
      n = int'(kn);
      u = ku;
    end
    for (int i = 0; i < n; i++) begin
      want.unit = u[i];
      want.last = (i == n - 1);
      pending_units.push_back(want);
    end
    bytes_sent++;
    if (used) bytes_used++;
  endtask

  // Drops the input valid and waits for every expected unit, then lets the clock run on.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_terminator(input logic v);
    cfg_write_en_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    term_on = v;
    cfg_write_en_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_units
    utf16_unit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected code unit %h run_last %b", $time, code_unit_o,
                 run_last_o);
        mismatch_count++;
      end else begin
        want = pending_units.pop_front();
        units_checked++;
        if (code_unit_o !== want.unit) begin
          $display("%0t: code_unit expected %h, got %h", $time, want.unit, code_unit_o);
          mismatch_count++;
        end
        if (run_last_o !== want.last) begin
          $display("%0t: run_last expected %b, got %b", $time, want.last, run_last_o);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and a long hold when asked.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        hold_out = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
        else stall_left = pick_gap();
      end
    end
  end

  initial begin
    int start_used;
    rst_ni = 1'b0;
    cfg_write_en_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i = 1'b0;
    byte_value_i = 8'h00;
    bytes_following_i = 2'd0;
    cp_acc = '0;
    cont_left = 2'd0;
    drop_rest = 1'b0;
    term_on = AppendTermReset;
    sender_quiet = 1'b0;
    hold_out = 1'b0;
    // Typed rows assume the terminator is on.
    dir_rows = '{
      '{8'h41, 2'd0, 1'b1, 2'd2, 16'h0041, TermUnit, 16'h0000},
      '{8'h00, 2'd0, 1'b1, 2'd2, 16'h0000, TermUnit, 16'h0000},
      '{8'h7F, 2'd3, 1'b1, 2'd1, 16'h007F, 16'h0000, 16'h0000},
      '{8'h80, 2'd3, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hBF, 2'd3, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hF8, 2'd3, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hFF, 2'd3, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hC2, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hA9, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hE2, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'h82, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hAC, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hF0, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'h9F, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'h98, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'h80, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hF7, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hBF, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hBF, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hBF, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hC3, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'h41, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hE0, 2'd1, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'h41, 2'd1, 1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'hE2, 2'd0, 1'b1, 2'd1, TermUnit, 16'h0000, 16'h0000},
      '{8'hE2, 2'd3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
      '{8'h82, 2'd0, 1'b1, 2'd1, TermUnit, 16'h0000, 16'h0000}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_terminator(1'b1);

    for (int i = 0; i < DirCount; i++) begin
      send_item(dir_rows[i].b, dir_rows[i].bf, dir_rows[i].known, dir_rows[i].n,
                {dir_rows[i].u2, dir_rows[i].u1, dir_rows[i].u0});
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_terminator(ph % 2 == 1);
      // The long output hold lets the input side back up and stall.
      if (ph == 1 || ph == 3) hold_out = 1'b1;
      start_used = bytes_used;
      while (bytes_used - start_used < PhaseBytes) begin
        build_string();
        sender_quiet = ($urandom_range(0, 3) == 0);
        foreach (text_bytes[i]) send_item(text_bytes[i].b, text_bytes[i].bf, 1'b0, 2'd0, '0);
      end
      sender_quiet = 1'b0;
      drain();
    end

    $display("Sent %0d bytes in %0d random strings plus the directed table; %0d code units",
             bytes_sent, strings_sent, units_checked);
    $display("checked with the terminator both on and off, under random and long stalls.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
